// ----- hdl/kmc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// K-means clustering package
// Shared types, codes and default sizes for the k-means clustering block.
// ----------------------------------------------------------------------------
package kmc_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int DIMENSIONS_DEF = 20;
    localparam int CLUSTERS_DEF   = 3;
    localparam int COORD_W        = 16;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic REG_NUM_POINTS = 1'b0;
    localparam logic REG_MAX_ITER   = 1'b1;

    localparam logic [10:0] NUM_POINTS_RST = 11'd1024;
    localparam logic [15:0] MAX_ITER_RST   = 16'd1000;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;
    localparam logic [1:0] MODE_NOP  = 2'd3;

    typedef enum logic [1:0] {
        OP_SEED,
        OP_ASSIGN,
        OP_ACCUM
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_SEED,
        ST_PASS,
        ST_ASSIGN,
        ST_DRAIN_A,
        ST_ACCUM,
        ST_DRAIN_B,
        ST_DIV_SEL,
        ST_DIV_WAIT,
        ST_PASS_END,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [9:0]         point_index;
        logic [4:0]         dim_index;
        logic signed [15:0] coordinate;
    } item_t;

    typedef struct packed {
        logic [2:0]  cluster_index;
        logic [15:0] iteration_count;
        logic        converged;
    } result_t;

endpackage

// ----- hdl/kmc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kmc_ram #(
    parameter int WIDTH = kmc_pkg::COORD_W,
    parameter int DEPTH = kmc_pkg::MAX_POINTS_DEF
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/kmc_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centroid divider
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module kmc_divider #(
    parameter int MAX_POINTS = kmc_pkg::MAX_POINTS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [$clog2(MAX_POINTS)+15:0]  dividend,
    input  logic [$clog2(MAX_POINTS):0]            divisor,
    output logic                                   done,
    output logic signed [15:0]                     quotient
);

    localparam int PW    = $clog2(MAX_POINTS);
    localparam int SUM_W = PW + 16;
    localparam int CNT_W = PW + 1;
    localparam int SW    = $clog2(SUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [SW-1:0]    step_reg;
    logic [SUM_W-1:0] quo_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] div_reg;
    logic             neg_reg;
    logic [CNT_W:0]   trial;
    logic             fits;
    logic [15:0]      qlow;

    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= SW'(SUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - SW'(1);
                if (step_reg == SW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            rem_reg <= '0;
            div_reg <= divisor;
            neg_reg <= dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= CNT_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_reg <= trial[CNT_W-1:0];
            end
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
        end
    end

    assign qlow     = quo_reg[15:0];
    assign quotient = neg_reg ? -qlow : qlow;
    assign done     = done_reg;

endmodule

// ----- hdl/kmc_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster cell
// Holds one centroid with its member sums and count, scores each passing
// point against the centroid and hands the stream on to its neighbor.
// ----------------------------------------------------------------------------
module kmc_cell #(
    parameter int MAX_POINTS = kmc_pkg::MAX_POINTS_DEF,
    parameter int DIMENSIONS = kmc_pkg::DIMENSIONS_DEF,
    parameter int CLUSTERS   = kmc_pkg::CLUSTERS_DEF,
    parameter int IDX        = 0
) (
    clk,
    rst_n,
    stream_in,
    ctl,
    stream_out,
    sum_out,
    count_out
);

    localparam int PW     = $clog2(MAX_POINTS);
    localparam int DW     = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
    localparam int CW     = $clog2(CLUSTERS);
    localparam int DIST_W = 32 + $clog2(DIMENSIONS);
    localparam int SUM_W  = PW + 16;
    localparam int CNT_W  = PW + 1;

    typedef struct packed {
        logic               valid;
        kmc_pkg::op_t       op;
        logic               last;
        logic [DW-1:0]      dim;
        logic [PW-1:0]      point;
        logic [CW-1:0]      cluster;
        logic signed [15:0] coord;
        logic               has_best;
        logic [DIST_W-1:0]  best_dist;
        logic [CW-1:0]      best_idx;
    } stream_t;

    typedef struct packed {
        logic               clr;
        logic               div_active;
        logic [DW-1:0]      dim;
        logic               cen_we;
        logic [CW-1:0]      cen_sel;
        logic signed [15:0] cen_val;
    } ctl_t;

    input  logic                    clk;
    input  logic                    rst_n;
    input  stream_t                 stream_in;
    input  ctl_t                    ctl;
    output stream_t                 stream_out;
    output logic signed [SUM_W-1:0] sum_out;
    output logic [CNT_W-1:0]        count_out;

    logic signed [15:0]      cen_reg [DIMENSIONS];
    logic signed [SUM_W-1:0] sum_reg [DIMENSIONS];
    logic [CNT_W-1:0]        count_reg;
    logic [DIST_W-1:0]       acc_reg;
    stream_t                 out_reg;
    stream_t                 out_next;

    logic [DW-1:0]           rd_idx;
    logic signed [SUM_W-1:0] sum_rd;
    logic signed [16:0]      diff;
    logic [15:0]             mag;
    logic [31:0]             sq;
    logic [DIST_W-1:0]       dist_acc;
    logic                    take_own;
    logic                    is_mine;
    logic                    do_assign;
    logic                    do_accum;
    logic                    do_seed;

    assign rd_idx   = ctl.div_active ? ctl.dim : stream_in.dim;
    assign sum_rd   = sum_reg[rd_idx];
    assign diff     = 17'(stream_in.coord) - 17'(cen_reg[stream_in.dim]);
    assign mag      = diff[16] ? 16'(-diff) : diff[15:0];
    assign sq       = 32'(mag) * 32'(mag);
    assign dist_acc = ((stream_in.dim == '0) ? '0 : acc_reg) + DIST_W'(sq);
    assign take_own = !stream_in.has_best || (dist_acc < stream_in.best_dist);
    assign is_mine  = stream_in.cluster == CW'(IDX);

    assign do_assign = stream_in.valid && (stream_in.op == kmc_pkg::OP_ASSIGN);
    assign do_accum  = stream_in.valid && (stream_in.op == kmc_pkg::OP_ACCUM) && is_mine;
    assign do_seed   = stream_in.valid && (stream_in.op == kmc_pkg::OP_SEED) && is_mine;

    always_comb
    begin
        out_next = stream_in;
        if (do_assign && stream_in.last && take_own)
        begin
            out_next.has_best  = 1'b1;
            out_next.best_dist = dist_acc;
            out_next.best_idx  = CW'(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            out_reg <= out_next;
            if (ctl.clr)
            begin
                count_reg <= '0;
            end
            else if (do_accum && stream_in.last)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_assign)
        begin
            acc_reg <= dist_acc;
        end
        if (ctl.clr)
        begin
            for (int d = 0; d < DIMENSIONS; d++)
            begin
                sum_reg[d] <= '0;
            end
        end
        else if (do_accum)
        begin
            sum_reg[rd_idx] <= sum_rd + SUM_W'(stream_in.coord);
        end
        if (do_seed)
        begin
            cen_reg[stream_in.dim] <= stream_in.coord;
        end
        else if (ctl.cen_we && (ctl.cen_sel == CW'(IDX)))
        begin
            cen_reg[ctl.dim] <= ctl.cen_val;
        end
    end

    assign stream_out = out_reg;
    assign sum_out    = sum_rd;
    assign count_out  = count_reg;

endmodule

// ----- hdl/kmeans_clustering.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// K-means clustering
// Lloyd k-means over stored points, with a chain of one cell per cluster.
// ----------------------------------------------------------------------------
// Items arrive on item_valid/item_stall; results leave on
// result_valid/result_stall through an output register.
// A load item writes one coordinate if its indices are in range; no result.
// A read item passes through the ST_READ state and then the output register
// before its result is valid.
// A run item clears all MAX_POINTS assignments, seeds the centroids from
// points 0 to CLUSTERS-1 and then runs passes. Each pass streams the first
// num_points points (at most MAX_POINTS) through the cell chain twice, once to
// assign and once to sum, at one coordinate per cycle, and then divides each
// centroid coordinate of a non-empty cluster in a shared divider.
// While a run or read is in progress item_stall is high. item_stall is also
// high while a result waits and result_stall is high.
// The user must write the two configuration registers over the APB port only
// while idle; the block does not enforce this. Reset clears the control state
// and sets the configuration registers to 1024 points and 1000 passes; stored
// points are undefined until loaded and a read before any run returns 0.
// ----------------------------------------------------------------------------
module kmeans_clustering #(
    parameter int MAX_POINTS = kmc_pkg::MAX_POINTS_DEF,
    parameter int DIMENSIONS = kmc_pkg::DIMENSIONS_DEF,
    parameter int CLUSTERS   = kmc_pkg::CLUSTERS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  kmc_pkg::item_t              item,
    output logic                        result_valid,
    input  logic                        result_stall,
    output kmc_pkg::result_t            result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kmc_pkg::APB_AW-1:0]  paddr,
    input  logic [kmc_pkg::APB_DW-1:0]  pwdata,
    output logic [kmc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    localparam int PW        = $clog2(MAX_POINTS);
    localparam int DW        = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
    localparam int CW        = $clog2(CLUSTERS);
    localparam int DIST_W    = 32 + $clog2(DIMENSIONS);
    localparam int SUM_W     = PW + 16;
    localparam int CNT_W     = PW + 1;
    localparam int PT_DEPTH  = MAX_POINTS * (2 ** DW);
    localparam int DRAIN_LEN = CLUSTERS + 2;
    localparam int DRW       = $clog2(DRAIN_LEN + 1);

    typedef struct packed {
        logic               valid;
        kmc_pkg::op_t       op;
        logic               last;
        logic [DW-1:0]      dim;
        logic [PW-1:0]      point;
        logic [CW-1:0]      cluster;
        logic signed [15:0] coord;
        logic               has_best;
        logic [DIST_W-1:0]  best_dist;
        logic [CW-1:0]      best_idx;
    } stream_t;

    typedef struct packed {
        logic               clr;
        logic               div_active;
        logic [DW-1:0]      dim;
        logic               cen_we;
        logic [CW-1:0]      cen_sel;
        logic signed [15:0] cen_val;
    } ctl_t;

    kmc_pkg::state_t  state_reg, state_next;
    logic [10:0]      num_points_reg;
    logic [15:0]      max_iter_reg;
    logic [PW-1:0]    p_reg, p_next;
    logic [DW-1:0]    d_reg, d_next;
    logic [CW-1:0]    c_reg, c_next;
    logic [DRW-1:0]   drain_reg, drain_next;
    logic [15:0]      iter_reg, iter_next;
    logic             changed_reg, changed_next;
    logic             conv_reg, conv_next;
    logic             ever_run_reg, ever_run_next;
    logic             rd_zero_reg, rd_zero_next;
    stream_t          meta_reg, meta_next;
    logic             out_valid_reg;
    kmc_pkg::result_t out_reg;

    logic             accept;
    logic             out_load;
    kmc_pkg::result_t out_data;
    logic             cfg_we;
    logic [CNT_W-1:0] n_pts;
    logic             p_last;
    logic             d_last;
    logic             c_last;

    logic               pt_we;
    logic [PW+DW-1:0]   pt_waddr;
    logic [15:0]        pt_rdata;
    logic               as_we;
    logic [PW-1:0]      as_waddr;
    logic [CW-1:0]      as_wdata;
    logic [PW-1:0]      as_raddr;
    logic [CW-1:0]      as_rdata;

    stream_t            chain [CLUSTERS+1];
    stream_t            src;
    stream_t            tail;
    ctl_t               ctl;
    logic signed [SUM_W-1:0] cell_sum [CLUSTERS];
    logic [CNT_W-1:0]        cell_cnt [CLUSTERS];
    logic signed [SUM_W-1:0] sel_sum;
    logic [CNT_W-1:0]        sel_cnt;
    logic               div_start;
    logic               div_done;
    logic signed [15:0] div_q;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg <= kmc_pkg::NUM_POINTS_RST;
            max_iter_reg   <= kmc_pkg::MAX_ITER_RST;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == kmc_pkg::REG_MAX_ITER)
            begin
                max_iter_reg <= pwdata[15:0];
            end
            else
            begin
                num_points_reg <= pwdata[10:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == kmc_pkg::REG_MAX_ITER)
        begin
            prdata = {16'd0, max_iter_reg};
        end
        else
        begin
            prdata = {21'd0, num_points_reg};
        end
    end

    always_comb
    begin
        if (int'(num_points_reg) > MAX_POINTS)
        begin
            n_pts = CNT_W'(MAX_POINTS);
        end
        else
        begin
            n_pts = CNT_W'(num_points_reg);
        end
    end

    assign p_last = (CNT_W'(p_reg) + CNT_W'(1)) == n_pts;
    assign d_last = d_reg == DW'(DIMENSIONS - 1);
    assign c_last = c_reg == CW'(CLUSTERS - 1);

    assign item_stall = (state_reg != kmc_pkg::ST_IDLE) || (out_valid_reg && result_stall);
    assign accept     = item_valid && !item_stall;

    // Storage.
    assign pt_waddr = {PW'(item.point_index), DW'(item.dim_index)};
    assign as_raddr = (state_reg == kmc_pkg::ST_IDLE) ? PW'(item.point_index) : p_reg;

    kmc_ram #(
        .WIDTH (kmc_pkg::COORD_W),
        .DEPTH (PT_DEPTH)
    ) u_point_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (item.coordinate),
        .raddr ({p_reg, d_reg}),
        .rdata (pt_rdata)
    );

    kmc_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_POINTS)
    ) u_assign_ram (
        .clk   (clk),
        .we    (as_we),
        .waddr (as_waddr),
        .wdata (as_wdata),
        .raddr (as_raddr),
        .rdata (as_rdata)
    );

    // Cell chain.
    always_comb
    begin
        src           = meta_reg;
        src.coord     = pt_rdata;
        src.has_best  = 1'b0;
        src.best_dist = '0;
        src.best_idx  = '0;
        if (meta_reg.op != kmc_pkg::OP_SEED)
        begin
            src.cluster = as_rdata;
        end
    end

    assign chain[0] = src;
    assign tail     = chain[CLUSTERS];

    for (genvar k = 0; k < CLUSTERS; k++)
    begin : g_cell
        kmc_cell #(
            .MAX_POINTS (MAX_POINTS),
            .DIMENSIONS (DIMENSIONS),
            .CLUSTERS   (CLUSTERS),
            .IDX        (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .stream_in  (chain[k]),
            .ctl        (ctl),
            .stream_out (chain[k+1]),
            .sum_out    (cell_sum[k]),
            .count_out  (cell_cnt[k])
        );
    end

    assign sel_sum = cell_sum[c_reg];
    assign sel_cnt = cell_cnt[c_reg];

    kmc_divider #(
        .MAX_POINTS (MAX_POINTS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sel_sum),
        .divisor  (sel_cnt),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kmc_pkg::ST_IDLE;
            p_reg         <= '0;
            d_reg         <= '0;
            c_reg         <= '0;
            drain_reg     <= '0;
            iter_reg      <= '0;
            changed_reg   <= 1'b0;
            conv_reg      <= 1'b0;
            ever_run_reg  <= 1'b0;
            rd_zero_reg   <= 1'b0;
            meta_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            p_reg        <= p_next;
            d_reg        <= d_next;
            c_reg        <= c_next;
            drain_reg    <= drain_next;
            iter_reg     <= iter_next;
            changed_reg  <= changed_next;
            conv_reg     <= conv_next;
            ever_run_reg <= ever_run_next;
            rd_zero_reg  <= rd_zero_next;
            meta_reg     <= meta_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_data;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        p_next         = p_reg;
        d_next         = d_reg;
        c_next         = c_reg;
        drain_next     = drain_reg;
        iter_next      = iter_reg;
        changed_next   = changed_reg;
        conv_next      = conv_reg;
        ever_run_next  = ever_run_reg;
        rd_zero_next   = rd_zero_reg;
        meta_next      = '0;
        out_load       = 1'b0;
        out_data       = '0;
        pt_we          = 1'b0;
        as_we          = 1'b0;
        as_waddr       = tail.point;
        as_wdata       = tail.best_idx;
        div_start      = 1'b0;
        ctl.clr        = 1'b0;
        ctl.div_active = (state_reg == kmc_pkg::ST_DIV_SEL)
                      || (state_reg == kmc_pkg::ST_DIV_WAIT);
        ctl.dim        = d_reg;
        ctl.cen_we     = 1'b0;
        ctl.cen_sel    = c_reg;
        ctl.cen_val    = div_q;

        if (tail.valid && (tail.op == kmc_pkg::OP_ASSIGN) && tail.last
            && (tail.best_idx != tail.cluster))
        begin
            as_we        = 1'b1;
            changed_next = 1'b1;
        end

        unique case (state_reg)
            kmc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.mode)
                        kmc_pkg::MODE_LOAD:
                        begin
                            pt_we = (int'(item.point_index) < MAX_POINTS)
                                 && (int'(item.dim_index) < DIMENSIONS);
                        end
                        kmc_pkg::MODE_RUN:
                        begin
                            ever_run_next = 1'b1;
                            iter_next     = '0;
                            conv_next     = 1'b0;
                            p_next        = '0;
                            d_next        = '0;
                            state_next    = kmc_pkg::ST_CLEAR;
                        end
                        kmc_pkg::MODE_READ:
                        begin
                            rd_zero_next = !(int'(item.point_index) < MAX_POINTS)
                                        || !ever_run_reg;
                            state_next   = kmc_pkg::ST_READ;
                        end
                        kmc_pkg::MODE_NOP:
                        begin
                            state_next = kmc_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            kmc_pkg::ST_READ:
            begin
                out_load               = 1'b1;
                out_data.cluster_index = rd_zero_reg ? 3'd0 : 3'(as_rdata);
                state_next             = kmc_pkg::ST_IDLE;
            end
            kmc_pkg::ST_CLEAR:
            begin
                as_we    = 1'b1;
                as_waddr = p_reg;
                as_wdata = '0;
                if (p_reg == PW'(MAX_POINTS - 1))
                begin
                    p_next     = '0;
                    state_next = kmc_pkg::ST_SEED;
                end
                else
                begin
                    p_next = p_reg + PW'(1);
                end
            end
            kmc_pkg::ST_SEED:
            begin
                meta_next.valid   = 1'b1;
                meta_next.op      = kmc_pkg::OP_SEED;
                meta_next.last    = d_last;
                meta_next.dim     = d_reg;
                meta_next.point   = p_reg;
                meta_next.cluster = CW'(p_reg);
                if (d_last)
                begin
                    d_next = '0;
                    if (p_reg == PW'(CLUSTERS - 1))
                    begin
                        p_next     = '0;
                        state_next = kmc_pkg::ST_PASS;
                    end
                    else
                    begin
                        p_next = p_reg + PW'(1);
                    end
                end
                else
                begin
                    d_next = d_reg + DW'(1);
                end
            end
            kmc_pkg::ST_PASS:
            begin
                if (iter_reg == max_iter_reg)
                begin
                    state_next = kmc_pkg::ST_DONE;
                end
                else
                begin
                    ctl.clr      = 1'b1;
                    changed_next = 1'b0;
                    p_next       = '0;
                    d_next       = '0;
                    c_next       = '0;
                    if (n_pts == '0)
                    begin
                        state_next = kmc_pkg::ST_DIV_SEL;
                    end
                    else
                    begin
                        state_next = kmc_pkg::ST_ASSIGN;
                    end
                end
            end
            kmc_pkg::ST_ASSIGN,
            kmc_pkg::ST_ACCUM:
            begin
                meta_next.valid = 1'b1;
                meta_next.op    = (state_reg == kmc_pkg::ST_ASSIGN) ? kmc_pkg::OP_ASSIGN
                                                                    : kmc_pkg::OP_ACCUM;
                meta_next.last  = d_last;
                meta_next.dim   = d_reg;
                meta_next.point = p_reg;
                if (d_last)
                begin
                    d_next = '0;
                    if (p_last)
                    begin
                        p_next     = '0;
                        drain_next = '0;
                        state_next = (state_reg == kmc_pkg::ST_ASSIGN) ? kmc_pkg::ST_DRAIN_A
                                                                       : kmc_pkg::ST_DRAIN_B;
                    end
                    else
                    begin
                        p_next = p_reg + PW'(1);
                    end
                end
                else
                begin
                    d_next = d_reg + DW'(1);
                end
            end
            kmc_pkg::ST_DRAIN_A,
            kmc_pkg::ST_DRAIN_B:
            begin
                drain_next = drain_reg + DRW'(1);
                if (drain_reg == DRW'(DRAIN_LEN - 1))
                begin
                    c_next     = '0;
                    d_next     = '0;
                    state_next = (state_reg == kmc_pkg::ST_DRAIN_A) ? kmc_pkg::ST_ACCUM
                                                                    : kmc_pkg::ST_DIV_SEL;
                end
            end
            kmc_pkg::ST_DIV_SEL,
            kmc_pkg::ST_DIV_WAIT:
            begin
                if ((state_reg == kmc_pkg::ST_DIV_SEL) && (sel_cnt != '0))
                begin
                    div_start  = 1'b1;
                    state_next = kmc_pkg::ST_DIV_WAIT;
                end
                else if ((state_reg == kmc_pkg::ST_DIV_SEL) || div_done)
                begin
                    ctl.cen_we = (state_reg == kmc_pkg::ST_DIV_WAIT);
                    state_next = kmc_pkg::ST_DIV_SEL;
                    if (d_last)
                    begin
                        d_next = '0;
                        if (c_last)
                        begin
                            c_next     = '0;
                            state_next = kmc_pkg::ST_PASS_END;
                        end
                        else
                        begin
                            c_next = c_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        d_next = d_reg + DW'(1);
                    end
                end
            end
            kmc_pkg::ST_PASS_END:
            begin
                iter_next = iter_reg + 16'd1;
                if (!changed_reg)
                begin
                    conv_next  = 1'b1;
                    state_next = kmc_pkg::ST_DONE;
                end
                else
                begin
                    state_next = kmc_pkg::ST_PASS;
                end
            end
            kmc_pkg::ST_DONE:
            begin
                out_load                 = 1'b1;
                out_data.iteration_count = iter_reg;
                out_data.converged       = conv_reg;
                state_next               = kmc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = kmc_pkg::ST_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ----- hdl/kmc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// K-means clustering checker
// Port-level assertions on the result and item channels, bound to the top level.
// ----------------------------------------------------------------------------
module kmc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       item_valid,
    input logic                       item_stall,
    input kmc_pkg::item_t             item,
    input logic                       result_valid,
    input logic                       result_stall,
    input kmc_pkg::result_t           result,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [kmc_pkg::APB_AW-1:0] paddr,
    input logic [kmc_pkg::APB_DW-1:0] pwdata,
    input logic [kmc_pkg::APB_DW-1:0] prdata,
    input logic                       pready
);

    // A stalled result stays and holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // A result is either a read answer or a run report, never a mix.
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.cluster_index == 3'd0)
                      || ((result.iteration_count == 16'd0) && !result.converged))
        else $error("result mixes read and run fields");

    // Convergence needs at least one pass.
    a_conv: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.converged |-> result.iteration_count != 16'd0)
        else $error("converged with zero passes");

    // An item is never taken while a newly presented result is stalled.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) && result_stall |-> item_stall)
        else $error("item accepted while result is stalled");

endmodule

bind kmeans_clustering kmc_checker u_kmc_checker (.*);

// ----- sim/kmc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// K-means clustering scoreboard
// Watches the item, result and register ports of the k-means block, keeps its
// own copy of the stored points, assignments and centroids, works out the
// result of every run and read item and compares each result field by field.
// ----------------------------------------------------------------------------
module kmc_scoreboard (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  logic                       item_stall,
    input  kmc_pkg::item_t             item,
    input  logic                       result_valid,
    input  logic                       result_stall,
    input  kmc_pkg::result_t           result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [kmc_pkg::APB_AW-1:0] paddr,
    input  logic [kmc_pkg::APB_DW-1:0] pwdata,
    input  logic                       pready,
    output int                         fails,
    output int                         pending
);

    localparam int NP = kmc_pkg::MAX_POINTS_DEF;
    localparam int ND = kmc_pkg::DIMENSIONS_DEF;
    localparam int NC = kmc_pkg::CLUSTERS_DEF;

    logic signed [15:0] coords [NP][ND];
    logic signed [15:0] centers [NC][ND];
    logic [2:0]         member_of [NP];
    logic [10:0]        points_cfg;
    logic [15:0]        iter_cfg;
    kmc_pkg::result_t   expected_q [$];

    assign pending = expected_q.size();

    function automatic longint sq_distance(int p, int c);
        longint acc;
        int diff;
        acc = 0;
        for (int d = 0; d < ND; d++)
        begin
            diff = int'(coords[p][d]) - int'(centers[c][d]);
            acc += longint'(diff) * longint'(diff);
        end
        return acc;
    endfunction

    task automatic cluster_points(output logic [15:0] passes, output logic conv);
        int n;
        int best_c;
        int pass_cnt;
        int cnt [NC];
        longint best;
        longint dd;
        longint sums [NC][ND];
        bit moved;
        n = (points_cfg > NP) ? NP : int'(points_cfg);
        for (int c = 0; c < NC; c++)
            for (int d = 0; d < ND; d++)
                centers[c][d] = coords[c][d];
        for (int p = 0; p < NP; p++)
            member_of[p] = '0;
        pass_cnt = 0;
        conv = 1'b0;
        while (pass_cnt < int'(iter_cfg))
        begin
            moved = 1'b0;
            for (int p = 0; p < n; p++)
            begin
                best = sq_distance(p, 0);
                best_c = 0;
                for (int c = 1; c < NC; c++)
                begin
                    dd = sq_distance(p, c);
                    if (dd < best)
                    begin
                        best = dd;
                        best_c = c;
                    end
                end
                if (member_of[p] != 3'(best_c))
                begin
                    member_of[p] = 3'(best_c);
                    moved = 1'b1;
                end
            end
            for (int c = 0; c < NC; c++)
            begin
                cnt[c] = 0;
                for (int d = 0; d < ND; d++)
                    sums[c][d] = 0;
            end
            for (int p = 0; p < n; p++)
            begin
                for (int d = 0; d < ND; d++)
                    sums[member_of[p]][d] += longint'(coords[p][d]);
                cnt[member_of[p]]++;
            end
            for (int c = 0; c < NC; c++)
                if (cnt[c] != 0)
                    for (int d = 0; d < ND; d++)
                        centers[c][d] = 16'(sums[c][d] / longint'(cnt[c]));
            pass_cnt++;
            if (!moved)
            begin
                conv = 1'b1;
                break;
            end
        end
        passes = 16'(pass_cnt);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        kmc_pkg::result_t exp_r;
        kmc_pkg::result_t got;
        logic [15:0] passes;
        logic conv;
        if (!rst_n)
        begin
            for (int p = 0; p < NP; p++)
            begin
                member_of[p] = '0;
                for (int d = 0; d < ND; d++)
                    coords[p][d] = '0;
            end
            points_cfg = kmc_pkg::NUM_POINTS_RST;
            iter_cfg = kmc_pkg::MAX_ITER_RST;
            fails = 0;
            expected_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == kmc_pkg::REG_NUM_POINTS)
                    points_cfg = pwdata[10:0];
                else
                    iter_cfg = pwdata[15:0];
            end
            if (result_valid && !result_stall)
            begin
                got = result;
                if (expected_q.size() == 0)
                begin
                    $error("result with no item outstanding: %h", got);
                    fails++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (got.cluster_index !== exp_r.cluster_index)
                    begin
                        $error("cluster_index expected %0d actual %0d",
                               exp_r.cluster_index, got.cluster_index);
                        fails++;
                    end
                    if (got.iteration_count !== exp_r.iteration_count)
                    begin
                        $error("iteration_count expected %0d actual %0d",
                               exp_r.iteration_count, got.iteration_count);
                        fails++;
                    end
                    if (got.converged !== exp_r.converged)
                    begin
                        $error("converged expected %0d actual %0d",
                               exp_r.converged, got.converged);
                        fails++;
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                case (item.mode)
                    kmc_pkg::MODE_LOAD:
                    begin
                        if (item.dim_index < ND)
                            coords[item.point_index][item.dim_index] = item.coordinate;
                    end
                    kmc_pkg::MODE_RUN:
                    begin
                        cluster_points(passes, conv);
                        exp_r.cluster_index = '0;
                        exp_r.iteration_count = passes;
                        exp_r.converged = conv;
                        expected_q.push_back(exp_r);
                    end
                    kmc_pkg::MODE_READ:
                    begin
                        exp_r.cluster_index = member_of[item.point_index];
                        exp_r.iteration_count = '0;
                        exp_r.converged = 1'b0;
                        expected_q.push_back(exp_r);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// K-means clustering testbench
// Loads clustered and random points, runs clustering under several point
// counts and pass limits, reads back assignments, and lets the scoreboard
// compare every result while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int ND = kmc_pkg::DIMENSIONS_DEF;
    localparam int NC = kmc_pkg::CLUSTERS_DEF;
    localparam int WATCHDOG_LIMIT = 1500000;

    logic                       clk;
    logic                       rst_n;
    logic                       item_valid;
    logic                       item_stall;
    kmc_pkg::item_t             item;
    logic                       result_valid;
    logic                       result_stall;
    kmc_pkg::result_t           result;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [kmc_pkg::APB_AW-1:0] paddr;
    logic [kmc_pkg::APB_DW-1:0] pwdata;
    logic [kmc_pkg::APB_DW-1:0] prdata;
    logic                       pready;
    int                         fails;
    int                         pending;
    int                         burst_left;
    int                         idle_cycles;
    int                         stall_style;
    int                         cyc;
    int                         centers [NC][ND];

    kmeans_clustering dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    kmc_scoreboard u_scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .fails        (fails),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc % 300 == 0)
            stall_style <= $urandom_range(0, 3);
        case (stall_style)
            0: result_stall <= 1'b0;
            1: result_stall <= ($urandom_range(0, 2) == 0);
            2: result_stall <= ($urandom_range(0, 3) != 0);
            default: result_stall <= (cyc % 5 < 2);
        endcase
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send(kmc_pkg::item_t it);
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(0, 15);
        end
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 || item_stall)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    function automatic kmc_pkg::item_t make_item(logic [1:0] m, int p, int d, int v);
        kmc_pkg::item_t it;
        it.mode = m;
        it.point_index = 10'(p);
        it.dim_index = 5'(d);
        it.coordinate = 16'(v);
        return it;
    endfunction

    function automatic int near_value(int c, int d);
        return centers[c][d] + int'($urandom_range(0, 4000)) - 2000;
    endfunction

    task automatic pick_centers();
        for (int c = 0; c < NC; c++)
            for (int d = 0; d < ND; d++)
                centers[c][d] = int'($urandom_range(0, 40000)) - 20000;
    endtask

    task automatic load_points(int count);
        int c;
        for (int p = 0; p < count; p++)
        begin
            c = $urandom_range(0, NC - 1);
            for (int d = 0; d < ND; d++)
                send(make_item(kmc_pkg::MODE_LOAD, p, d, near_value(c, d)));
        end
    endtask

    task automatic run_phase(int n, int iters, int count);
        int filled;
        int r;
        int c;
        filled = (n < NC) ? NC : n;
        write_reg(kmc_pkg::REG_NUM_POINTS, 32'(n));
        write_reg(kmc_pkg::REG_MAX_ITER, 32'(iters));
        pick_centers();
        load_points(filled);
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
                send(make_item(kmc_pkg::MODE_RUN, $urandom_range(0, 1023),
                               $urandom_range(0, 31), $urandom));
            else if (r < 30)
                send(make_item(kmc_pkg::MODE_READ, ($urandom_range(0, 1))
                               ? $urandom_range(0, filled - 1) : $urandom_range(0, 1023),
                               $urandom_range(0, 31), $urandom));
            else if (r < 34)
                send(make_item(kmc_pkg::MODE_NOP, $urandom_range(0, 1023),
                               $urandom_range(0, 31), $urandom));
            else if (r < 85)
            begin
                c = $urandom_range(0, NC - 1);
                r = $urandom_range(0, ND - 1);
                send(make_item(kmc_pkg::MODE_LOAD, $urandom_range(0, filled - 1), r,
                               near_value(c, r)));
            end
            else
                send(make_item(kmc_pkg::MODE_LOAD, $urandom_range(0, 1023),
                               $urandom_range(0, 31), $urandom));
        end
        send(make_item(kmc_pkg::MODE_RUN, 0, 0, 0));
        settle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        burst_left = 0;
        idle_cycles = 0;
        stall_style = 0;
        cyc = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reads before any run, extreme coordinates in the seed points, then runs with no points and with no passes.
        send(make_item(kmc_pkg::MODE_READ, 0, 0, 0));
        send(make_item(kmc_pkg::MODE_READ, 1023, 31, -1));
        settle();
        write_reg(kmc_pkg::REG_NUM_POINTS, 32'd3);
        write_reg(kmc_pkg::REG_MAX_ITER, 32'd1);
        for (int p = 0; p < NC; p++)
            for (int d = 0; d < ND; d++)
                send(make_item(kmc_pkg::MODE_LOAD, p, d,
                               (p == 0) ? -32768 : (p == 1) ? 32767 : 0));
        send(make_item(kmc_pkg::MODE_LOAD, 1023, 19, 32767));
        send(make_item(kmc_pkg::MODE_LOAD, 5, 31, 1234));
        send(make_item(kmc_pkg::MODE_LOAD, 6, 20, -1234));
        send(make_item(kmc_pkg::MODE_NOP, 1023, 31, -1));
        send(make_item(kmc_pkg::MODE_RUN, 0, 0, 0));
        send(make_item(kmc_pkg::MODE_READ, 0, 0, 0));
        send(make_item(kmc_pkg::MODE_READ, 1, 0, 0));
        send(make_item(kmc_pkg::MODE_READ, 2, 0, 0));
        send(make_item(kmc_pkg::MODE_READ, 1023, 0, 0));
        settle();
        write_reg(kmc_pkg::REG_NUM_POINTS, 32'd0);
        write_reg(kmc_pkg::REG_MAX_ITER, 32'd65535);
        send(make_item(kmc_pkg::MODE_RUN, 0, 0, 0));
        settle();
        write_reg(kmc_pkg::REG_NUM_POINTS, 32'd1);
        write_reg(kmc_pkg::REG_MAX_ITER, 32'd0);
        send(make_item(kmc_pkg::MODE_RUN, 0, 0, 0));
        send(make_item(kmc_pkg::MODE_READ, 0, 0, 0));
        settle();

        run_phase(5, 65535, 120);
        run_phase(12, 1000, 120);
        run_phase(8, 20, 100);
        run_phase(3, 1, 100);
        run_phase(2, 7, 100);

        repeat (50) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
